@@ rtl/wcld_pkg.sv @@
// wcld_pkg: types, constants and the log2 mantissa table for the
// wavelet coefficient display mapper. No dependencies.
package wcld_pkg;

    // configuration register width and indexes
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    localparam int GRAY_W = 8;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

    // log2 of x carries this many fraction bits
    localparam int LOG_FRAC = 6;
    // 20 * L is built as (L << 4) + (L << 2)
    localparam int MUL_SH_HI = 4;
    localparam int MUL_SH_LO = 2;

    // per-item tag decided by the front part
    typedef struct packed {
        logic approx_band;
        logic frame_last;
    } item_tag_t;

    localparam int TAG_W = $bits(item_tag_t);

    // round(64 * log2(1 + m/64))
    function automatic logic [LOG_FRAC-1:0] log_mant(input logic [LOG_FRAC-1:0] m);
        logic [LOG_FRAC-1:0] t;
        case (m)
            6'd0:  t = 6'd0;   6'd1:  t = 6'd1;   6'd2:  t = 6'd3;   6'd3:  t = 6'd4;
            6'd4:  t = 6'd6;   6'd5:  t = 6'd7;   6'd6:  t = 6'd8;   6'd7:  t = 6'd10;
            6'd8:  t = 6'd11;  6'd9:  t = 6'd12;  6'd10: t = 6'd13;  6'd11: t = 6'd15;
            6'd12: t = 6'd16;  6'd13: t = 6'd17;  6'd14: t = 6'd18;  6'd15: t = 6'd19;
            6'd16: t = 6'd21;  6'd17: t = 6'd22;  6'd18: t = 6'd23;  6'd19: t = 6'd24;
            6'd20: t = 6'd25;  6'd21: t = 6'd26;  6'd22: t = 6'd27;  6'd23: t = 6'd28;
            6'd24: t = 6'd29;  6'd25: t = 6'd30;  6'd26: t = 6'd31;  6'd27: t = 6'd32;
            6'd28: t = 6'd34;  6'd29: t = 6'd35;  6'd30: t = 6'd35;  6'd31: t = 6'd36;
            6'd32: t = 6'd37;  6'd33: t = 6'd38;  6'd34: t = 6'd39;  6'd35: t = 6'd40;
            6'd36: t = 6'd41;  6'd37: t = 6'd42;  6'd38: t = 6'd43;  6'd39: t = 6'd44;
            6'd40: t = 6'd45;  6'd41: t = 6'd46;  6'd42: t = 6'd47;  6'd43: t = 6'd47;
            6'd44: t = 6'd48;  6'd45: t = 6'd49;  6'd46: t = 6'd50;  6'd47: t = 6'd51;
            6'd48: t = 6'd52;  6'd49: t = 6'd52;  6'd50: t = 6'd53;  6'd51: t = 6'd54;
            6'd52: t = 6'd55;  6'd53: t = 6'd56;  6'd54: t = 6'd56;  6'd55: t = 6'd57;
            6'd56: t = 6'd58;  6'd57: t = 6'd59;  6'd58: t = 6'd60;  6'd59: t = 6'd60;
            6'd60: t = 6'd61;  6'd61: t = 6'd62;  6'd62: t = 6'd63;  6'd63: t = 6'd63;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/wcld_front.sv @@
// wcld_front: configuration registers, raster position counters and
// per-item classification (approximation band, frame end). Uses wcld_pkg.
module wcld_front
    import wcld_pkg::*;
#(
    parameter int COEF_BITS = 24,
    parameter int MAX_SIDE  = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [COEF_BITS-1:0] in_coef,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [COEF_BITS-1:0] q_coef,
    output item_tag_t            q_tag
);

    localparam int CNT_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W  = ((SIDE_W > CFG_W) ? SIDE_W : CFG_W) + 1;

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;

    logic [CMP_W-1:0] w_eff, h_eff, col_ext, row_ext;
    logic             row_end, frame_end, approx;

    // register writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sides in effect, clamped to 1..MAX_SIDE
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = CMP_W'(1);
        else if (CMP_W'(image_width_reg) > CMP_W'(MAX_SIDE))
            w_eff = CMP_W'(MAX_SIDE);
        else
            w_eff = CMP_W'(image_width_reg);

        if (image_height_reg == '0)
            h_eff = CMP_W'(1);
        else if (CMP_W'(image_height_reg) > CMP_W'(MAX_SIDE))
            h_eff = CMP_W'(MAX_SIDE);
        else
            h_eff = CMP_W'(image_height_reg);
    end

    // classification of the current position
    assign col_ext   = CMP_W'(column_count_reg);
    assign row_ext   = CMP_W'(row_count_reg);
    assign approx    = (col_ext < (w_eff >> 1)) && (row_ext < (h_eff >> 1));
    assign row_end   = (col_ext + CMP_W'(1)) >= w_eff;
    assign frame_end = row_end && ((row_ext + CMP_W'(1)) >= h_eff);

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign q_coef   = in_coef;
    assign q_tag    = '{approx_band: approx, frame_last: frame_end};

    // position update
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (row_end)
        begin
            column_count_next = '0;
            row_count_next    = frame_end ? '0 : row_count_reg + CNT_W'(1);
        end
        else
        begin
            column_count_next = column_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (q_push)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

@@ rtl/wcld_queue.sv @@
// wcld_queue: short FIFO of classified items between front and back.
// Uses wcld_pkg only for house consistency of widths passed in.
module wcld_queue
    import wcld_pkg::*;
#(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow push");

endmodule

@@ rtl/wcld_back.sv @@
// wcld_back: magnitude, leading-one search, log2 table and scaling to a
// gray level, as a stalling pipeline with an output register. Uses wcld_pkg.
module wcld_back
    import wcld_pkg::*;
#(
    parameter int COEF_BITS = 24,
    parameter int FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [COEF_BITS-1:0] q_coef,
    input  item_tag_t            q_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [GRAY_W-1:0]    out_gray,
    output logic                 out_last
);

    localparam int X_W = COEF_BITS + 1;
    localparam int P_W = $clog2(X_W);
    localparam int L_W = P_W + LOG_FRAC + 1;
    localparam int G_W = L_W + MUL_SH_HI + 1;

    logic adv;

    // stage 1: magnitude, x = |v| + 1, approximation value
    logic [COEF_BITS-1:0] mag;
    logic [COEF_BITS-1:0] trunc;
    logic                 s1_valid_reg;
    logic [X_W-1:0]       s1_x_reg;
    logic [GRAY_W-1:0]    s1_approx_reg;
    item_tag_t            s1_tag_reg;

    // stage 2: leading-one position
    logic [P_W-1:0]       lead;
    logic                 s2_valid_reg;
    logic [X_W-1:0]       s2_x_reg;
    logic [P_W-1:0]       s2_p_reg;
    logic [GRAY_W-1:0]    s2_approx_reg;
    item_tag_t            s2_tag_reg;

    // stage 3: log2 with 6 fraction bits
    logic [X_W+LOG_FRAC-1:0] norm;
    logic [LOG_FRAC-1:0]     mant;
    logic                    s3_valid_reg;
    logic [L_W-1:0]          s3_l_reg;
    logic [GRAY_W-1:0]       s3_approx_reg;
    item_tag_t               s3_tag_reg;

    // output stage: 20 * L / 64 and saturation
    logic [G_W-1:0]    scaled;
    logic [G_W-1:0]    gray_log;
    logic [GRAY_W-1:0] gray_sel;
    logic              out_valid_reg;
    logic [GRAY_W-1:0] out_gray_reg;
    logic              out_last_reg;

    // whole pipeline moves unless the output item is held
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    assign mag   = q_coef[COEF_BITS-1] ? (~q_coef + COEF_BITS'(1)) : q_coef;
    assign trunc = mag >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg      <= X_W'(mag) + (X_W'(1) << FRAC_BITS);
            s1_approx_reg <= (trunc > COEF_BITS'(GRAY_MAX)) ? GRAY_MAX : GRAY_W'(trunc);
            s1_tag_reg    <= q_tag;
        end
    end

    // priority encoder, highest set bit wins
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < X_W; i++)
        begin
            if (s1_x_reg[i])
                lead = P_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_x_reg      <= s1_x_reg;
            s2_p_reg      <= lead;
            s2_approx_reg <= s1_approx_reg;
            s2_tag_reg    <= s1_tag_reg;
        end
    end

    // six bits under the leading one, zero-filled when x is short
    assign norm = {s2_x_reg, {LOG_FRAC{1'b0}}} >> s2_p_reg;
    assign mant = norm[LOG_FRAC-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_l_reg <= ((L_W'(s2_p_reg) - L_W'(FRAC_BITS)) << LOG_FRAC)
                        + L_W'(log_mant(mant));
            s3_approx_reg <= s2_approx_reg;
            s3_tag_reg    <= s2_tag_reg;
        end
    end

    assign scaled   = (G_W'(s3_l_reg) << MUL_SH_HI) + (G_W'(s3_l_reg) << MUL_SH_LO);
    assign gray_log = scaled >> LOG_FRAC;
    assign gray_sel = s3_tag_reg.approx_band ? s3_approx_reg
                    : ((gray_log > G_W'(GRAY_MAX)) ? GRAY_MAX : GRAY_W'(gray_log));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_gray_reg <= gray_sel;
            out_last_reg <= s3_tag_reg.frame_last;
        end
    end

    // valid bits of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_gray  = out_gray_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/wavelet_coef_log_display_core.sv @@
// Wavelet coefficient to display gray level mapper, top level.
// Ties wcld_front, wcld_queue and wcld_back together; uses wcld_pkg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata take one signed coefficient per item, in raster
//   order. m_tvalid/m_tready/m_tdata/m_tlast give one gray level per item;
//   m_tlast marks the final pixel of a frame.
//   cfg_wen/cfg_index/cfg_data write image_width (index 0) and image_height
//   (index 1); write them only while no item is in flight.
// Timing:
//   One item per clock sustained while m_tready stays high. A result passes
//   through its queue entry and then the magnitude register, which the queue
//   head feeds directly, then leading-one search, log2 table, and the 20x
//   scale into the output register, one register each.
// Reset:
//   Clears the position counters, the queue and all stage valid bits;
//   width and height return to 640 and 480.
// Stall:
//   While m_tready is low the back pipeline holds; the two-entry queue then
//   fills and s_tready drops. No item is dropped or repeated.
module wavelet_coef_log_display_core
    import wcld_pkg::*;
#(
    parameter int COEF_BITS = 24,
    parameter int FRAC_BITS = 8,
    parameter int MAX_SIDE  = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((COEF_BITS+7)/8)*8-1:0] s_tdata,   // coefficient
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [GRAY_W-1:0]              m_tdata,   // gray_level
    output logic                           m_tlast    // frame_last
);

    localparam int Q_W = COEF_BITS + TAG_W;

    logic                 q_push, q_full, q_pop, q_valid;
    logic [COEF_BITS-1:0] front_coef, back_coef;
    item_tag_t            front_tag, back_tag;
    logic [Q_W-1:0]       q_head;

    wcld_front #(
        .COEF_BITS (COEF_BITS),
        .MAX_SIDE  (MAX_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_coef   (s_tdata[COEF_BITS-1:0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_coef    (front_coef),
        .q_tag     (front_tag)
    );

    wcld_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_tag, front_coef}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_data (q_head)
    );

    assign back_coef = q_head[COEF_BITS-1:0];
    assign back_tag  = item_tag_t'(q_head[Q_W-1:COEF_BITS]);

    wcld_back #(
        .COEF_BITS (COEF_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_coef    (back_coef),
        .q_tag     (back_tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_gray  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
